FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, masked while reset is high.
`define EHT_ASSERT_IMPL(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("implication check failed");

// Implication checked in the next cycle, active through reset.
`define EHT_ASSERT_NEXT(lbl, clk, trig, prop) \
  lbl: assert property (@(posedge clk) (trig) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/ehtab_pkg.sv
// Shared types and constants of the extendible hash table.
package ehtab_pkg;

  localparam int KEY_W      = 32;
  localparam int PAY_W      = 64;
  localparam int DEPTH_W    = 4;
  localparam int CNT_W      = 2;
  localparam int BASE_LD    = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

FILE: rtl/ehtab_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ehtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ehtab_front.sv
// Front end: takes requests, masks and classifies them, queues them for the back end.
module ehtab_front #(
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           op,
  input  logic [31:0]          key,
  input  logic [63:0]          payload,
  output logic                 busy,
  output ehtab_pkg::q_head_t   head,
  input  ehtab_pkg::back_ctl_t ctl
);
  import ehtab_pkg::*;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
  localparam logic [PAY_W-1:0] PAY_MASK = {PAY_W{1'b1}} >> (PAY_W - PAYLOAD_BITS);

  req_t       ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  req_t       req_in;

  assign busy = (count == 2'd2) || ctl.clearing;
  assign push = start && !busy;

  always_comb begin
    req_in.op      = op_t'(op);
    req_in.key     = key & KEY_MASK;
    req_in.payload = payload & PAY_MASK;
  end

  assign head.valid = (count != 2'd0);
  assign head.req   = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        ent[wp] <= req_in;
        wp      <= ~wp;
      end
      if (ctl.pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(ctl.pop);
    end
  end

endmodule

FILE: rtl/ehtab_back.sv
// Back end: directory, bucket fill and record stores and the sequencer that runs each request.
module ehtab_back #(
  parameter int MAX_DEPTH    = 10,
  parameter int BUCKET_SLOTS = 3,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [3:0]            cfg_wr_data,
  input  ehtab_pkg::q_head_t    head,
  output ehtab_pkg::back_ctl_t  ctl,
  output logic                  done,
  output logic                  status,
  output logic                  hit,
  output logic [63:0]           found_payload,
  output logic [1:0]            match_count,
  output logic [3:0]            global_depth,
  output logic [3:0]            local_depth,
  output logic                  last
);
  import ehtab_pkg::*;

  localparam int DW   = $clog2(MAX_DEPTH + 1);
  localparam int FW   = $clog2(BUCKET_SLOTS + 1);
  localparam int SW   = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int DIRN = 1 << MAX_DEPTH;
  localparam int RAW  = MAX_DEPTH + SW;
  localparam int RECW = KEY_BITS + PAYLOAD_BITS;
  localparam logic [MAX_DEPTH-1:0] ALL1 = {MAX_DEPTH{1'b1}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIR_RD, S_DIR_WT, S_FILL_WT, S_REC_RD, S_REC_WT,
    S_DBL_RD, S_DBL_WT, S_SPL_RD, S_SPL_WT, S_FILL_W1, S_FILL_W2, S_DIR_UPD
  } state_t;

  typedef struct packed {
    logic               status;
    logic               hit;
    logic [PAY_W-1:0]   pay;
    logic [CNT_W-1:0]   cnt;
    logic [DEPTH_W-1:0] gd;
    logic [DEPTH_W-1:0] ld;
    logic               last;
  } res_t;

  state_t               state;
  req_t                 cur;
  logic [DW-1:0]        depth;
  logic [DW-1:0]        ld;
  logic [MAX_DEPTH-1:0] name;
  logic [MAX_DEPTH-1:0] walk;
  logic [MAX_DEPTH-1:0] s;
  logic [MAX_DEPTH-1:0] j;
  logic [FW-1:0]        fill;
  logic [FW-1:0]        idx;
  logic [FW-1:0]        keep;
  logic [FW-1:0]        moved;
  logic [FW-1:0]        cnt;
  logic [FW-1:0]        k;
  logic                 pass;
  res_t                 res;

  logic                 dir_we;
  logic [MAX_DEPTH-1:0] dir_waddr;
  logic [DW-1:0]        dir_wdata;
  logic [MAX_DEPTH-1:0] dir_raddr;
  logic [DW-1:0]        dir_rdata;
  logic                 fill_we;
  logic [MAX_DEPTH-1:0] fill_waddr;
  logic [FW-1:0]        fill_wdata;
  logic [MAX_DEPTH-1:0] fill_raddr;
  logic [FW-1:0]        fill_rdata;
  logic                 rec_we;
  logic [RAW-1:0]       rec_waddr;
  logic [RECW-1:0]      rec_wdata;
  logic [RAW-1:0]       rec_raddr;
  logic [RECW-1:0]      rec_rdata;

  logic [MAX_DEPTH-1:0] key_idx;
  logic [MAX_DEPTH-1:0] dmask;
  logic [MAX_DEPTH-1:0] name_new;
  logic [MAX_DEPTH-1:0] nname;
  logic [MAX_DEPTH-1:0] jmask;
  logic [KEY_BITS-1:0]  rec_key;
  logic [KEY_BITS-1:0]  rec_key_sh;
  logic                 key_match;
  logic                 up;
  logic [FW-1:0]        idx_inc;
  logic [FW-1:0]        cnt_nx;
  logic [FW-1:0]        k_inc;
  logic                 ins_ok;
  logic [DW-1:0]        cfg_clamp;

  function automatic res_t mk_res(logic st, logic ht, logic [PAY_W-1:0] p,
                                  logic [FW-1:0] c, logic [DW-1:0] gd,
                                  logic [DW-1:0] l, logic lst);
    res_t r;
    r.status = st;
    r.hit    = ht;
    r.pay    = p;
    r.cnt    = CNT_W'(c);
    r.gd     = DEPTH_W'(gd);
    r.ld     = DEPTH_W'(l);
    r.last   = lst;
    return r;
  endfunction

  ehtab_ram #(.WIDTH(DW), .DEPTH(DIRN)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );

  ehtab_ram #(.WIDTH(FW), .DEPTH(DIRN)) u_fill (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_rdata)
  );

  ehtab_ram #(.WIDTH(RECW), .DEPTH(1 << RAW)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );

  assign key_idx    = cur.key[MAX_DEPTH-1:0];
  assign dmask      = ~(ALL1 << depth);
  assign name_new   = key_idx & ~(ALL1 << dir_rdata);
  assign nname      = name | (MAX_DEPTH'(1) << ld);
  assign jmask      = ~(ALL1 << (depth - ld));
  assign rec_key    = rec_rdata[RECW-1:PAYLOAD_BITS];
  assign rec_key_sh = rec_key >> ld;
  assign up         = rec_key_sh[0];
  assign key_match  = (rec_key == cur.key[KEY_BITS-1:0]);
  assign idx_inc    = idx + FW'(1);
  assign cnt_nx     = cnt + FW'(key_match);
  assign k_inc      = k + FW'(1);
  assign ins_ok     = (fill_rdata < FW'(BUCKET_SLOTS));

  always_comb begin
    if (cfg_wr_data < 4'(BASE_LD)) begin
      cfg_clamp = DW'(BASE_LD);
    end else if (int'(cfg_wr_data) > MAX_DEPTH) begin
      cfg_clamp = DW'(MAX_DEPTH);
    end else begin
      cfg_clamp = DW'(cfg_wr_data);
    end
  end

  assign ctl.clearing = (state == S_CLEAR);
  assign ctl.pop      = (state == S_IDLE) && head.valid && !cfg_wr_en;

  always_comb begin
    dir_we     = 1'b0;
    dir_waddr  = walk;
    dir_wdata  = DW'(BASE_LD);
    dir_raddr  = key_idx & dmask;
    fill_we    = 1'b0;
    fill_waddr = walk;
    fill_wdata = '0;
    fill_raddr = name_new;
    rec_we     = 1'b0;
    rec_waddr  = {name, keep[SW-1:0]};
    rec_wdata  = rec_rdata;
    rec_raddr  = {name, idx[SW-1:0]};
    case (state)
      S_CLEAR: begin
        dir_we  = 1'b1;
        fill_we = 1'b1;
      end
      S_DBL_RD: begin
        dir_raddr = s;
      end
      S_DBL_WT: begin
        dir_we    = 1'b1;
        dir_waddr = s | (MAX_DEPTH'(1) << depth);
        dir_wdata = dir_rdata;
      end
      S_DIR_UPD: begin
        dir_we    = 1'b1;
        dir_waddr = name | (j << ld);
        dir_wdata = ld + DW'(1);
      end
      S_FILL_WT: begin
        if (cur.op == OP_INSERT && ins_ok) begin
          fill_we    = 1'b1;
          fill_waddr = name;
          fill_wdata = fill_rdata + FW'(1);
          rec_we     = 1'b1;
          rec_waddr  = {name, fill_rdata[SW-1:0]};
          rec_wdata  = {cur.key[KEY_BITS-1:0], cur.payload[PAYLOAD_BITS-1:0]};
        end
      end
      S_REC_WT: begin
        if (cur.op == OP_DELETE) begin
          rec_we = !key_match;
          if (idx_inc == fill) begin
            fill_we    = 1'b1;
            fill_waddr = name;
            fill_wdata = key_match ? keep : keep + FW'(1);
          end
        end
      end
      S_SPL_WT: begin
        rec_we = 1'b1;
        if (up) begin
          rec_waddr = {nname, moved[SW-1:0]};
        end
      end
      S_FILL_W1: begin
        fill_we    = 1'b1;
        fill_waddr = name;
        fill_wdata = keep;
      end
      S_FILL_W2: begin
        fill_we    = 1'b1;
        fill_waddr = nname;
        fill_wdata = moved;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      walk  <= '0;
      depth <= DW'(BASE_LD);
      done  <= 1'b0;
    end else if (cfg_wr_en) begin
      state <= S_CLEAR;
      walk  <= '0;
      depth <= cfg_clamp;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          walk <= walk + MAX_DEPTH'(1);
          if (walk == ALL1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head.valid) begin
            cur   <= head.req;
            state <= S_DIR_RD;
          end
        end
        S_DIR_RD: begin
          state <= S_DIR_WT;
        end
        S_DIR_WT: begin
          ld   <= dir_rdata;
          name <= name_new;
          if (cur.op == OP_NOP) begin
            done  <= 1'b1;
            res   <= mk_res(1'b0, 1'b0, '0, '0, depth, dir_rdata, 1'b1);
            state <= S_IDLE;
          end else begin
            state <= S_FILL_WT;
          end
        end
        S_FILL_WT: begin
          fill  <= fill_rdata;
          idx   <= '0;
          keep  <= '0;
          moved <= '0;
          cnt   <= '0;
          k     <= '0;
          pass  <= 1'b0;
          s     <= '0;
          if (cur.op == OP_INSERT) begin
            if (ins_ok) begin
              done  <= 1'b1;
              res   <= mk_res(1'b0, 1'b0, '0, '0, depth, ld, 1'b1);
              state <= S_IDLE;
            end else if (ld == DW'(MAX_DEPTH)) begin
              done  <= 1'b1;
              res   <= mk_res(1'b1, 1'b0, '0, '0, depth, ld, 1'b1);
              state <= S_IDLE;
            end else if (ld >= depth) begin
              state <= S_DBL_RD;
            end else begin
              state <= S_SPL_RD;
            end
          end else if (fill_rdata == '0) begin
            done  <= 1'b1;
            res   <= mk_res(1'b0, 1'b0, '0, '0, depth, ld, 1'b1);
            state <= S_IDLE;
          end else begin
            state <= S_REC_RD;
          end
        end
        S_REC_RD: begin
          state <= S_REC_WT;
        end
        S_REC_WT: begin
          idx   <= idx_inc;
          state <= S_REC_RD;
          if (cur.op == OP_DELETE) begin
            cnt <= cnt_nx;
            if (!key_match) begin
              keep <= keep + FW'(1);
            end
            if (idx_inc == fill) begin
              done  <= 1'b1;
              res   <= mk_res(1'b0, 1'b0, '0, cnt_nx, depth, ld, 1'b1);
              state <= S_IDLE;
            end
          end else if (!pass) begin
            cnt <= cnt_nx;
            if (idx_inc == fill) begin
              if (cnt_nx == '0) begin
                done  <= 1'b1;
                res   <= mk_res(1'b0, 1'b0, '0, '0, depth, ld, 1'b1);
                state <= S_IDLE;
              end else begin
                pass <= 1'b1;
                idx  <= '0;
              end
            end
          end else if (key_match) begin
            done <= 1'b1;
            res  <= mk_res(1'b0, 1'b1, PAY_W'(rec_rdata[PAYLOAD_BITS-1:0]), cnt,
                           depth, ld, k_inc == cnt);
            k    <= k_inc;
            if (k_inc == cnt) begin
              state <= S_IDLE;
            end
          end
        end
        S_DBL_RD: begin
          state <= S_DBL_WT;
        end
        S_DBL_WT: begin
          s <= s + MAX_DEPTH'(1);
          if (s == dmask) begin
            depth <= depth + DW'(1);
            state <= S_SPL_RD;
          end else begin
            state <= S_DBL_RD;
          end
        end
        S_SPL_RD: begin
          state <= S_SPL_WT;
        end
        S_SPL_WT: begin
          idx <= idx_inc;
          if (up) begin
            moved <= moved + FW'(1);
          end else begin
            keep <= keep + FW'(1);
          end
          state <= (idx_inc == fill) ? S_FILL_W1 : S_SPL_RD;
        end
        S_FILL_W1: begin
          state <= S_FILL_W2;
        end
        S_FILL_W2: begin
          j     <= '0;
          state <= S_DIR_UPD;
        end
        S_DIR_UPD: begin
          j <= j + MAX_DEPTH'(1);
          if (j == jmask) begin
            state <= S_DIR_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status        = res.status;
  assign hit           = res.hit;
  assign found_payload = res.pay;
  assign match_count   = res.cnt;
  assign global_depth  = res.gd;
  assign local_depth   = res.ld;
  assign last          = res.last;

endmodule

FILE: rtl/extendible_hash_table_core.sv
// Top level of the extendible hash table: front end, request queue and back end.
//
// Usage:
//   Requests enter on start/op/key/payload and are taken at a clock edge where
//   start is high and busy is low. op selects insert, delete or lookup.
//   Results leave on done plus the result ports, one cycle per result; the
//   receiver cannot hold them off. Insert, delete and the unused op give one
//   result; a lookup gives one result per matching record, or one miss.
//   last marks the final result of a request.
//   A two-entry queue sits between the front end and the back end, so new
//   requests are taken while the back end still works.
//   The back end runs one request at a time and pops the next one at the edge
//   that ends the previous final result.
//   Reset and every write of initial_global_depth (cfg_wr_en/cfg_wr_data)
//   start a clearing pass over all 2^MAX_DEPTH directory and fill entries;
//   busy stays high through it.
module extendible_hash_table_core #(
  parameter int MAX_DEPTH    = 10,
  parameter int BUCKET_SLOTS = 3,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] key,
  input  logic [63:0] payload,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  output logic        done,
  output logic        status,
  output logic        hit,
  output logic [63:0] found_payload,
  output logic [1:0]  match_count,
  output logic [3:0]  global_depth,
  output logic [3:0]  local_depth,
  output logic        last
);
  import ehtab_pkg::*;

  // Queue head toward the back end, and pop/clearing back toward the front.
  q_head_t   head;
  back_ctl_t ctl;

  ehtab_front #(
    .KEY_BITS(KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .op(op),
    .key(key),
    .payload(payload),
    .busy(busy),
    .head(head),
    .ctl(ctl)
  );

  // Back end owns the stores; it runs one request at a time.
  ehtab_back #(
    .MAX_DEPTH(MAX_DEPTH),
    .BUCKET_SLOTS(BUCKET_SLOTS),
    .KEY_BITS(KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .head(head),
    .ctl(ctl),
    .done(done),
    .status(status),
    .hit(hit),
    .found_payload(found_payload),
    .match_count(match_count),
    .global_depth(global_depth),
    .local_depth(local_depth),
    .last(last)
  );

endmodule

FILE: rtl/ehtab_checker.sv
// Port-level checks of the extendible hash table, bound to the top level.
`include "assert_macros.svh"

module ehtab_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic        status,
  input logic        hit,
  input logic [63:0] found_payload,
  input logic [1:0]  match_count,
  input logic [3:0]  global_depth,
  input logic [3:0]  local_depth,
  input logic        last
);

  `EHT_ASSERT_NEXT(a_clear_after_reset, clk, rst, busy)
  `EHT_ASSERT_IMPL(a_miss_no_payload, clk, rst, done && !hit, found_payload == 64'd0)
  `EHT_ASSERT_IMPL(a_drop_result, clk, rst, done && status, last && !hit && match_count == 2'd0)
  `EHT_ASSERT_IMPL(a_hit_count, clk, rst, done && hit, match_count != 2'd0)
  `EHT_ASSERT_IMPL(a_depth_floor, clk, rst, done, global_depth >= 4'd2 && local_depth >= 4'd2)

endmodule

bind extendible_hash_table_core ehtab_checker u_chk (.*);

FILE: bench/tb_top.sv
// Self-checking testbench for the extendible hash table core.
module tb_top;
  import ehtab_pkg::*;

  localparam int MAX_D   = 10;
  localparam int SLOTS   = 3;
  localparam int DIR_N   = 1 << MAX_D;
  localparam int N_RAND  = 140;

  typedef struct {
    logic        status;
    logic        hit;
    logic [63:0] pay;
    logic [1:0]  cnt;
    logic [3:0]  gd;
    logic [3:0]  ld;
    logic        last;
  } table_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op = OP_NOP;
  logic [31:0] key = '0;
  logic [63:0] payload = '0;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = '0;
  logic        done, status, hit, last;
  logic [63:0] found_payload;
  logic [1:0]  match_count;
  logic [3:0]  global_depth, local_depth;

  // Shadow copy of the table: directory local depths, bucket fills, records.
  logic [3:0]  dir_depth;
  logic [3:0]  dir_ld   [DIR_N];
  logic [1:0]  bkt_fill [DIR_N];
  logic [31:0] rec_key  [DIR_N*SLOTS];
  logic [63:0] rec_pay  [DIR_N*SLOTS];

  table_resp_t pending_resp[$];
  int          mismatches = 0;
  logic [31:0] key_pool[16];

  extendible_hash_table_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .key(key),
    .payload(payload), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .done(done), .status(status), .hit(hit), .found_payload(found_payload),
    .match_count(match_count), .global_depth(global_depth),
    .local_depth(local_depth), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] mask_of(int n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  // Rebuild the empty table with a clamped starting depth.
  function automatic void table_clear(logic [3:0] d);
    dir_depth = (d < BASE_LD) ? 4'(BASE_LD) : (d > MAX_D) ? 4'(MAX_D) : d;
    for (int i = 0; i < DIR_N; i++) begin
      dir_ld[i] = 4'(BASE_LD);
      bkt_fill[i] = '0;
    end
  endfunction

  function automatic logic [3:0] ld_for(logic [31:0] k);
    return dir_ld[k & mask_of(dir_depth) & (DIR_N - 1)];
  endfunction

  // Split bucket nm of depth ld on key bit ld; double the directory first if needed.
  function automatic void shadow_split(logic [31:0] nm, int ld);
    logic [31:0] sib;
    int          keep, moved, sz;
    sib = nm | (32'd1 << ld);
    keep = 0;
    moved = 0;
    if (ld + 1 > dir_depth) begin
      sz = 1 << dir_depth;
      for (int s = 0; s < sz; s++) dir_ld[s + sz] = dir_ld[s];
      dir_depth++;
    end
    for (int i = 0; i < bkt_fill[nm]; i++) begin
      if ((rec_key[nm*SLOTS+i] & mask_of(ld + 1)) == sib) begin
        rec_key[sib*SLOTS+moved] = rec_key[nm*SLOTS+i];
        rec_pay[sib*SLOTS+moved] = rec_pay[nm*SLOTS+i];
        moved++;
      end else begin
        rec_key[nm*SLOTS+keep] = rec_key[nm*SLOTS+i];
        rec_pay[nm*SLOTS+keep] = rec_pay[nm*SLOTS+i];
        keep++;
      end
    end
    bkt_fill[nm] = 2'(keep);
    bkt_fill[sib] = 2'(moved);
    // Every aliasing slot of the old bucket gets the new depth.
    sz = 1 << dir_depth;
    for (int s = 0; s < sz; s++)
      if ((s & mask_of(ld)) == nm) dir_ld[s] = 4'(ld + 1);
  endfunction

  function automatic logic table_insert(logic [31:0] k, logic [63:0] p);
    int          ld;
    logic [31:0] nm;
    for (int it = 0; it <= MAX_D + 1; it++) begin
      ld = ld_for(k);
      nm = k & mask_of(ld) & (DIR_N - 1);
      if (bkt_fill[nm] < SLOTS) begin
        rec_key[nm*SLOTS+bkt_fill[nm]] = k;
        rec_pay[nm*SLOTS+bkt_fill[nm]] = p;
        bkt_fill[nm]++;
        return 1'b0;
      end
      if (ld + 1 > MAX_D) return 1'b1;
      shadow_split(nm, ld);
    end
    return 1'b1;
  endfunction

  // Apply one request to the shadow table and queue the responses it causes.
  function automatic void table_apply(op_t o, logic [31:0] k, logic [63:0] p);
    table_resp_t r;
    logic [31:0] nm;
    int          cnt, keep, n;
    r = '{status: 1'b0, hit: 1'b0, pay: '0, cnt: '0, gd: '0, ld: '0, last: 1'b1};
    cnt = 0;
    if (o == OP_INSERT || o == OP_NOP) begin
      if (o == OP_INSERT) r.status = table_insert(k, p);
      r.gd = dir_depth;
      r.ld = ld_for(k);
      pending_resp.push_back(r);
      return;
    end
    r.ld = ld_for(k);
    r.gd = dir_depth;
    nm = k & mask_of(r.ld) & (DIR_N - 1);
    if (o == OP_DELETE) begin
      keep = 0;
      for (int i = 0; i < bkt_fill[nm]; i++) begin
        if (rec_key[nm*SLOTS+i] == k) cnt++;
        else begin
          rec_key[nm*SLOTS+keep] = rec_key[nm*SLOTS+i];
          rec_pay[nm*SLOTS+keep] = rec_pay[nm*SLOTS+i];
          keep++;
        end
      end
      bkt_fill[nm] = 2'(keep);
      r.cnt = 2'(cnt);
      pending_resp.push_back(r);
      return;
    end
    for (int i = 0; i < bkt_fill[nm]; i++) if (rec_key[nm*SLOTS+i] == k) cnt++;
    if (cnt == 0) begin
      pending_resp.push_back(r);
      return;
    end
    n = 0;
    for (int i = 0; i < bkt_fill[nm]; i++) begin
      if (rec_key[nm*SLOTS+i] == k) begin
        n++;
        r.hit = 1'b1;
        r.pay = rec_pay[nm*SLOTS+i];
        r.cnt = 2'(cnt);
        r.last = (n == cnt);
        pending_resp.push_back(r);
      end
    end
  endfunction

  // Present one request at the falling edge and hold it until it is taken.
  task automatic send_request(op_t o, logic [31:0] k, logic [63:0] p);
    @(negedge clk);
    start <= 1'b1;
    op <= o;
    key <= k;
    payload <= p;
    do @(posedge clk); while (busy);
    table_apply(o, k, p);
  endtask

  // Drop start and stay quiet for a wait set by n.
  task automatic idle_cycles(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Drain all responses, let the core settle, then write the depth register.
  task automatic write_depth(logic [3:0] d);
    idle_cycles(1);
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (40) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    table_clear(d);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Compare every strobed response against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
      end else begin
        table_resp_t e;
        e = pending_resp.pop_front();
        if (status !== e.status || hit !== e.hit || found_payload !== e.pay ||
            match_count !== e.cnt || global_depth !== e.gd ||
            local_depth !== e.ld || last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp st%0b h%0b p%h c%0d gd%0d ld%0d l%0b",
                      " got st%0b h%0b p%h c%0d gd%0d ld%0d l%0b"},
                     e.status, e.hit, e.pay, e.cnt, e.gd, e.ld, e.last,
                     status, hit, found_payload, match_count, global_depth,
                     local_depth, last);
        end
      end
    end
  end

  // Every op, field extremes, lookup miss, the unused op, multiple matches.
  task automatic test_basic_ops();
    write_depth(4'd0);
    send_request(OP_LOOKUP, 32'h0, 64'h0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_INSERT, 32'h0, 64'h0);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 64'h0);
    send_request(OP_NOP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_INSERT, 32'h0, 64'hA5A5_5A5A_0F0F_F0F0);
    send_request(OP_LOOKUP, 32'h0, 64'h0);
    send_request(OP_DELETE, 32'h0, 64'h0);
    send_request(OP_DELETE, 32'h0, 64'h0);
    send_request(OP_LOOKUP, 32'h0, 64'h0);
    idle_cycles(5);
  endtask

  // Repeated inserts of one key split up to the depth limit and then drop.
  task automatic test_depth_limit();
    write_depth(4'd15);
    for (int i = 0; i < 4; i++) send_request(OP_INSERT, 32'h1234_5678, 64'(i));
    send_request(OP_LOOKUP, 32'h1234_5678, 64'h0);
    write_depth(4'd2);
    for (int i = 0; i < 5; i++) send_request(OP_INSERT, 32'h0000_0003, 64'(i + 7));
    send_request(OP_LOOKUP, 32'h0000_0003, 64'h0);
    send_request(OP_DELETE, 32'h0000_0003, 64'h0);
    idle_cycles(3);
  endtask

  // Bursts of mostly inserts and lookups over a small key pool.
  task automatic test_random_traffic();
    int   sel;
    op_t  o;
    logic [31:0] k;
    for (int n = 0; n < N_RAND; n++) begin
      if (n % 40 == 0) begin
        write_depth(4'($urandom_range(15)));
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
      end
      sel = $urandom_range(99);
      o = (sel < 45) ? OP_INSERT : (sel < 65) ? OP_DELETE : (sel < 95) ? OP_LOOKUP : OP_NOP;
      k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(15)];
      send_request(o, k, {$urandom, $urandom});
      if ($urandom_range(3) == 0) idle_cycles($urandom_range(12));
    end
    idle_cycles(1);
  endtask

  initial begin
    table_clear(4'd2);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_depth_limit();
    test_random_traffic();
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ehtab_pkg.sv
rtl/ehtab_ram.sv
rtl/ehtab_front.sv
rtl/ehtab_back.sv
rtl/extendible_hash_table_core.sv
rtl/ehtab_checker.sv
bench/tb_top.sv
